// ===== hw/rtl/ajb_pkg.sv =====
// ----------------------------------------------------------------------------
// ajb_pkg - shared types and constants of the jitter buffer controller
// Operation codes, configuration register indexes, reset values and the
// word types that pass between the front end, the queue and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

    // Default number of packet length slots.
    localparam int PACKET_SLOTS_DEF = 64;

    // Entries of the queue between front end and engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Field widths.
    localparam int COUNT_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int BPM_W    = 12;
    localparam int MS_W     = 10;
    localparam int TICK_W   = 24;
    localparam int DEPTH_W  = 22;
    localparam int DROP_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [DROP_W-1:0]  DROP_MAX  = {DROP_W{1'b1}};

    // Function codes on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAX_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUMP_MS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INTERVAL = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [BPM_W-1:0]  RST_BYTES_PER_MS   = 12'd192;
    localparam logic [MS_W-1:0]   RST_TARGET_MIN_MS  = 10'd40;
    localparam logic [MS_W-1:0]   RST_TARGET_MAX_MS  = 10'd400;
    localparam logic [MS_W-1:0]   RST_BUMP_MS        = 10'd30;
    localparam logic [MS_W-1:0]   RST_DECAY_MS       = 10'd5;
    localparam logic [TICK_W-1:0] RST_DECAY_INTERVAL = 24'd10000;

    // Classified operation handed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PULL = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [COUNT_W-1:0]   count;
    } op_t;

    // One result word.
    typedef struct packed {
        logic                 overflow;
        logic [DEPTH_W-1:0]   queued_bytes;
        logic [MS_W-1:0]      target_now;
        logic [DROP_W-1:0]    dropped_packets;
        logic                 underrun;
        logic [COUNT_W-1:0]   bytes_given;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ajb_front.sv =====
// ----------------------------------------------------------------------------
// ajb_front - input stage of the jitter buffer controller
// Registers each accepted word and classifies it into an engine operation.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ajb_pkg::COUNT_W-1:0] s_tdata,
    input  wire logic [ajb_pkg::FUNC_W-1:0]  s_tuser,
    output logic                             op_valid,
    input  wire logic                        op_ready,
    output ajb_pkg::op_t                     op
);
    import ajb_pkg::*;

    logic     valid_reg;
    op_t      op_reg;
    op_t      op_next;

    // A push of zero bytes changes nothing, so it travels as a no-op.
    always_comb begin
        op_next.count = s_tdata;
        case (s_tuser)
            FUNC_PUSH: op_next.kind = (s_tdata == '0) ? OP_NOP : OP_PUSH;
            FUNC_PULL: op_next.kind = OP_PULL;
            FUNC_TICK: op_next.kind = OP_TICK;
            default:   op_next.kind = OP_NOP;
        endcase
    end

    assign s_tready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg <= op_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ajb_fifo.sv =====
// ----------------------------------------------------------------------------
// ajb_fifo - operation queue between front end and engine
// A short first-in first-out queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_fifo (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wr_valid,
    output logic             wr_ready,
    input  wire ajb_pkg::op_t wr_op,
    output logic             rd_valid,
    input  wire logic        rd_ready,
    output ajb_pkg::op_t     rd_op
);
    import ajb_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    op_t                     entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic                    do_wr;
    logic                    do_rd;

    assign wr_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        ptr_inc = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ajb_engine.sv =====
// ----------------------------------------------------------------------------
// ajb_engine - sequencer of the jitter buffer controller
// Holds the packet length ring, the depth and target state and the
// configuration registers, carries out one operation at a time and keeps
// the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_engine #(
    parameter int PACKET_SLOTS = ajb_pkg::PACKET_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           op_valid,
    output logic                                op_ready,
    input  wire ajb_pkg::op_t                   op,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ajb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ajb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ajb_pkg::res_t                       res
);
    import ajb_pkg::*;

    localparam int SLOT_W = $clog2(PACKET_SLOTS);
    localparam int CNT_W  = $clog2(PACKET_SLOTS + 1);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_PUSH      = 11'b000_0000_0010,
        S_DECAY     = 11'b000_0000_0100,
        S_MUL       = 11'b000_0000_1000,
        S_CHECK     = 11'b000_0001_0000,
        S_DROP_TEST = 11'b000_0010_0000,
        S_DROP_SUB  = 11'b000_0100_0000,
        S_PULL      = 11'b000_1000_0000,
        S_PULL_LD   = 11'b001_0000_0000,
        S_PULL_END  = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    // Configuration.
    logic [BPM_W-1:0]  bpm_reg;
    logic [MS_W-1:0]   tmin_reg;
    logic [MS_W-1:0]   tmax_reg;
    logic [MS_W-1:0]   bump_reg;
    logic [MS_W-1:0]   decay_reg;
    logic [TICK_W-1:0] dint_reg;

    // Length ring.
    logic [COUNT_W-1:0] mem [PACKET_SLOTS];
    logic [COUNT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;

    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [SLOT_W-1:0]  head_reg,    head_next;
    logic [DEPTH_W-1:0] depth_reg,   depth_next;
    logic [COUNT_W-1:0] left_reg,    left_next;
    logic               started_reg, started_next;
    logic [MS_W-1:0]    target_reg,  target_next;
    logic [TICK_W-1:0]  ticks_reg,   ticks_next;

    // Per-operation working registers.
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [COUNT_W-1:0] given_reg,   given_next;
    logic               under_reg,   under_next;
    logic               ovf_reg,     ovf_next;
    logic [DROP_W-1:0]  drop_reg,    drop_next;
    logic [DEPTH_W-1:0] prod_reg,    prod_next;

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg,       out_next;

    // Helpers.
    logic [CNT_W:0]     wr_sum;
    logic [CNT_W:0]     wr_wrap;
    logic [SLOT_W-1:0]  head_inc;
    logic [DEPTH_W:0]   depth_sum;
    logic [DEPTH_W+1:0] prod3;
    logic [COUNT_W-1:0] rem;
    logic [COUNT_W-1:0] take;
    logic [MS_W-1:0]    decay_sub;
    logic [MS_W-1:0]    decay_val;
    logic [MS_W:0]      bump_sum;
    logic [MS_W-1:0]    bump_val;
    logic               ring_full;

    assign wr_sum    = (CNT_W+1)'(head_reg) + (CNT_W+1)'(cnt_reg);
    assign wr_wrap   = (wr_sum >= (CNT_W+1)'(PACKET_SLOTS)) ?
                       wr_sum - (CNT_W+1)'(PACKET_SLOTS) : wr_sum;
    assign mem_waddr = wr_wrap[SLOT_W-1:0];
    assign head_inc  = (head_reg == SLOT_W'(PACKET_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign ring_full = (cnt_reg == CNT_W'(PACKET_SLOTS));
    assign depth_sum = {1'b0, depth_reg} + (DEPTH_W+1)'(count_reg);
    assign prod3     = {1'b0, prod_reg, 1'b0} + {2'b00, prod_reg};
    assign rem       = count_reg - given_reg;
    assign take      = (rem < left_reg) ? rem : left_reg;
    assign decay_sub = (target_reg > decay_reg) ? target_reg - decay_reg : '0;
    assign decay_val = (decay_sub < tmin_reg) ? tmin_reg : decay_sub;
    assign bump_sum  = {1'b0, target_reg} + {1'b0, bump_reg};
    assign bump_val  = (bump_sum > {1'b0, tmax_reg}) ? tmax_reg : bump_sum[MS_W-1:0];

    assign op_ready  = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        depth_next     = depth_reg;
        left_next      = left_reg;
        started_next   = started_reg;
        target_next    = target_reg;
        ticks_next     = ticks_reg;
        count_next     = count_reg;
        given_next     = given_reg;
        under_next     = under_reg;
        ovf_next       = ovf_reg;
        drop_next      = drop_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                given_next = '0;
                under_next = 1'b0;
                ovf_next   = 1'b0;
                drop_next  = '0;
                count_next = op.count;
                if (op_valid) begin
                    case (op.kind)
                        OP_PUSH: state_next = S_PUSH;
                        OP_PULL: state_next = S_PULL;
                        OP_TICK: begin
                            if (ticks_reg != TICK_MAX) begin
                                ticks_next = ticks_reg + 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH: begin
                if (ring_full || depth_sum > (DEPTH_W+1)'(DEPTH_MAX)) begin
                    ovf_next = 1'b1;
                end else begin
                    mem_we     = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    depth_next = depth_sum[DEPTH_W-1:0];
                end
                state_next = (bpm_reg == '0) ? S_DONE : S_DECAY;
            end
            S_DECAY: begin
                if (ticks_reg >= dint_reg) begin
                    if (target_reg > tmin_reg) begin
                        target_next = decay_val;
                    end
                    ticks_next = '0;
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = DEPTH_W'(target_reg) * DEPTH_W'(bpm_reg);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = ((DEPTH_W+2)'(depth_reg) > prod3) ? S_DROP_TEST : S_DONE;
            end
            S_DROP_TEST: begin
                if (depth_reg > prod_reg && cnt_reg != '0) begin
                    head_next  = head_inc;
                    cnt_next   = cnt_reg - 1'b1;
                    if (drop_reg != DROP_MAX) begin
                        drop_next = drop_reg + 1'b1;
                    end
                    state_next = S_DROP_SUB;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DROP_SUB: begin
                depth_next = depth_reg - DEPTH_W'(rd_data_reg);
                state_next = S_DROP_TEST;
            end
            S_PULL: begin
                if (rem == '0) begin
                    state_next = S_PULL_END;
                end else if (left_reg == '0) begin
                    if (cnt_reg == '0) begin
                        state_next = S_PULL_END;
                    end else begin
                        head_next  = head_inc;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_PULL_LD;
                    end
                end else begin
                    given_next = given_reg + take;
                    left_next  = left_reg - take;
                end
            end
            S_PULL_LD: begin
                left_next    = rd_data_reg;
                depth_next   = depth_reg - DEPTH_W'(rd_data_reg);
                started_next = 1'b1;
                state_next   = S_PULL;
            end
            S_PULL_END: begin
                if (given_reg < count_reg) begin
                    under_next = 1'b1;
                    if (started_reg) begin
                        target_next = bump_val;
                        ticks_next  = '0;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next           = 1'b1;
                    out_next.bytes_given     = given_reg;
                    out_next.underrun        = under_reg;
                    out_next.dropped_packets = drop_reg;
                    out_next.target_now      = target_reg;
                    out_next.queued_bytes    = depth_reg;
                    out_next.overflow        = ovf_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Ring read runs every cycle at the head; the data is registered and used in the next cycle.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[head_reg];
        if (mem_we) begin
            mem[mem_waddr] <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            depth_reg     <= '0;
            left_reg      <= '0;
            started_reg   <= 1'b0;
            target_reg    <= RST_TARGET_MIN_MS;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
            bpm_reg       <= RST_BYTES_PER_MS;
            tmin_reg      <= RST_TARGET_MIN_MS;
            tmax_reg      <= RST_TARGET_MAX_MS;
            bump_reg      <= RST_BUMP_MS;
            decay_reg     <= RST_DECAY_MS;
            dint_reg      <= RST_DECAY_INTERVAL;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            depth_reg     <= depth_next;
            left_reg      <= left_next;
            started_reg   <= started_next;
            target_reg    <= target_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BYTES_PER_MS:   bpm_reg   <= cfg_wdata[BPM_W-1:0];
                    CFG_TARGET_MIN_MS:  tmin_reg  <= cfg_wdata[MS_W-1:0];
                    CFG_TARGET_MAX_MS:  tmax_reg  <= cfg_wdata[MS_W-1:0];
                    CFG_BUMP_MS:        bump_reg  <= cfg_wdata[MS_W-1:0];
                    CFG_DECAY_MS:       decay_reg <= cfg_wdata[MS_W-1:0];
                    CFG_DECAY_INTERVAL: dint_reg  <= cfg_wdata[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        given_reg <= given_next;
        under_reg <= under_next;
        ovf_reg   <= ovf_next;
        drop_reg  <= drop_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/adaptive_jitter_buffer_control_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_control_top - adaptive jitter buffer bookkeeping
// Tracks queued packet lengths, queued bytes and an adaptive target depth.
// ----------------------------------------------------------------------------
// Each input word is a push of a packet length, a render pull or a time
// tick; each produces exactly one result word. The front stage registers
// and classifies words into a two-entry queue, so input keeps flowing while
// the engine works and while a result waits to be taken, until the queue
// fills. The engine handles one operation at a time. A push stores the
// length unless the ring or the byte total would overflow; past a
// watermark of three times the target in bytes it drops oldest packets
// down to the target. A zero bytes-per-millisecond setting skips the
// watermark. A pull takes bytes from the packet in play and loads a new
// one from the ring as it runs out. Removal is paced by the single
// registered read port of the packet length memory: each packet removed
// takes a read state and an update state. The length memory holds no
// reset state and needs no clearing pass. Configuration is written through
// a plain write port and must only be changed while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_jitter_buffer_control_top #(
    parameter int PACKET_SLOTS = ajb_pkg::PACKET_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input words.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [15:0]                    s_axis_tdata,  // byte_count
    input  wire logic [1:0]                     s_axis_tuser,  // func
    // Result words.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // From bit 0: bytes_given[15:0], underrun, dropped_packets[6:0],
    // target_now[9:0], queued_bytes[21:0], overflow, zero padding.
    output logic [63:0]                         m_axis_tdata,
    // Configuration writes.
    input  wire logic                           cfg_wr_en,
    input  wire logic [ajb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ajb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ajb_pkg::*;

    op_t  front_op;
    op_t  queue_op;
    logic front_valid;
    logic queue_wr_ready;
    logic queue_valid;
    logic engine_ready;
    res_t result;

    // Front end: registers each word and turns it into an operation.
    ajb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .op_valid (front_valid),
        .op_ready (queue_wr_ready),
        .op       (front_op)
    );

    // The queue decouples classification from execution.
    ajb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (queue_wr_ready),
        .wr_op    (front_op),
        .rd_valid (queue_valid),
        .rd_ready (engine_ready),
        .rd_op    (queue_op)
    );

    // The engine owns the length ring, all state and the result register.
    ajb_engine #(
        .PACKET_SLOTS (PACKET_SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (queue_valid),
        .op_ready  (engine_ready),
        .op        (queue_op),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (result)
    );

    // The result fields are packed with the first declared field highest.
    assign m_axis_tdata = {7'b0, result};

endmodule

`default_nettype wire

// ===== hw/rtl/ajb_checker.sv =====
// ----------------------------------------------------------------------------
// ajb_checker - port-level checks on the jitter buffer controller
// Watches the result channel and the relations between result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // No result word is offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word offered straight after reset");

    // A stalled result word holds.
    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // A discarded packet comes from a push, which never gives bytes.
    a_overflow_is_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[56] |->
            m_axis_tdata[15:0] == 16'd0 && !m_axis_tdata[16])
        else $error("overflow reported on a word that is not a push");

    // Packets are only dropped on a push.
    a_drop_is_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[23:17] != 7'd0 |->
            m_axis_tdata[15:0] == 16'd0 && !m_axis_tdata[16])
        else $error("dropped packets reported on a word that is not a push");

endmodule

bind adaptive_jitter_buffer_control_top ajb_checker u_ajb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/adaptive_jitter_buffer_control_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_control_top_tb - self-checking bench for the jitter
// buffer bookkeeping block
// Drives push, pull, tick and unknown words through the input stream. A
// built-in predictor keeps its own ring of packet lengths and its own target,
// and works out the result word for every accepted input word. The
// comparison is field by field. A directed opening is followed by random
// phases under several register settings, including the extremes, with
// random idling on both streams, a long receiver hold-off and a calm stretch.
// ----------------------------------------------------------------------------

module adaptive_jitter_buffer_control_top_tb;

    import ajb_pkg::*;

    localparam int SLOTS        = PACKET_SLOTS_DEF;
    localparam int PHASE_WORDS  = 215;   // random words in each register phase
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int IDLE_PCT     = 22;    // chance of an idle cycle on each side
    // One pull may walk the whole ring, with a read and a load step a packet,
    // so this comfortably covers the longest operation after the last word.
    localparam int SETTLE_CYCLES = 250;
    localparam logic [1:0] FUNC_UNKNOWN = 2'(OP_NOP);

    // One input word: the function travels on tuser, the byte count on tdata.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] count;
    } bus_word_t;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // ------------------------------------------------------------------
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    adaptive_jitter_buffer_control_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------
    bus_word_t outgoing_words[$];   // words still to be offered to the block
    res_t      awaited_status[$];   // predicted result words, oldest first
    int        words_queued  = 0;   // words handed to the driver so far
    int        results_seen  = 0;   // result words matched against a prediction
    int        fault_count   = 0;
    logic      in_fire       = 1'b0; // an input word was taken at the last edge
    bit        calm          = 1'b0; // while set neither side idles
    int        holds_asked   = 0;
    int        holds_served  = 0;
    int        hold_left     = 0;

    // ------------------------------------------------------------------
    // Predictor state: the register copy and the buffer bookkeeping.
    // ------------------------------------------------------------------
    logic [BPM_W-1:0]   cfg_bpm      = RST_BYTES_PER_MS;
    logic [MS_W-1:0]    cfg_tmin     = RST_TARGET_MIN_MS;
    logic [MS_W-1:0]    cfg_tmax     = RST_TARGET_MAX_MS;
    logic [MS_W-1:0]    cfg_bump     = RST_BUMP_MS;
    logic [MS_W-1:0]    cfg_decay    = RST_DECAY_MS;
    logic [TICK_W-1:0]  cfg_interval = RST_DECAY_INTERVAL;

    logic [15:0]        len_ring[SLOTS];
    logic [6:0]         ring_fill    = '0;
    logic [5:0]         ring_head    = '0;
    logic [DEPTH_W-1:0] queued_total = '0;
    logic [15:0]        rest_left    = '0;  // unread part of the packet in play
    logic               rendering    = 1'b0;
    // The target starts from the reset value of the minimum; later writes of
    // the minimum register do not move it.
    logic [MS_W-1:0]    level_ms     = RST_TARGET_MIN_MS;
    logic [TICK_W-1:0]  ticks_idle   = '0;

    // Removes the oldest queued packet and gives back its length.
    function automatic logic [15:0] take_oldest();
        logic [15:0] len;
        len          = len_ring[ring_head];
        ring_head    = ring_head + 6'd1;
        ring_fill    = ring_fill - 7'd1;
        queued_total = queued_total - DEPTH_W'(len);
        return len;
    endfunction

    // Applies one operation to the bookkeeping and returns the result word
    // the block must produce for it.
    function automatic res_t account_op(input logic [1:0] func, input logic [15:0] count);
        res_t             r;
        int unsigned      given;
        int unsigned      take;
        int unsigned      slot;
        int unsigned      next_ms;
        longint unsigned  goal_bytes;
        r     = '0;
        given = 0;
        if (func == FUNC_PUSH && count != 16'd0) begin
            // A full ring, or a total that would leave its 22-bit range, loses
            // the new packet; the decay and the watermark still run at a nonzero rate.
            if (ring_fill >= SLOTS ||
                32'(queued_total) + 32'(count) > 32'(DEPTH_MAX)) begin
                r.overflow = 1'b1;
            end else begin
                slot           = (32'(ring_head) + 32'(ring_fill)) % SLOTS;
                len_ring[slot] = count;
                ring_fill      = ring_fill + 7'd1;
                queued_total   = queued_total + DEPTH_W'(count);
            end
            if (cfg_bpm != '0) begin
                if (ticks_idle >= cfg_interval) begin
                    if (level_ms > cfg_tmin) begin
                        next_ms = (level_ms > cfg_decay) ? level_ms - cfg_decay : 0;
                        if (next_ms < cfg_tmin) next_ms = cfg_tmin;
                        level_ms = next_ms[MS_W-1:0];
                    end
                    ticks_idle = '0;
                end
                // Past three times the target, drop oldest packets down to the
                // target itself; the packet just queued may go too.
                goal_bytes = longint'(level_ms) * longint'(cfg_bpm);
                if (queued_total > goal_bytes * 3) begin
                    while (queued_total > goal_bytes && ring_fill != '0) begin
                        void'(take_oldest());
                        if (r.dropped_packets != DROP_MAX)
                            r.dropped_packets = r.dropped_packets + 7'd1;
                    end
                end
            end
        end else if (func == FUNC_PULL) begin
            while (given < count) begin
                if (rest_left == '0) begin
                    if (ring_fill == '0) break;
                    rest_left = take_oldest();
                    rendering = 1'b1;
                end
                take = 32'(count) - given;
                if (take > rest_left) take = rest_left;
                given     = given + take;
                rest_left = rest_left - 16'(take);
            end
            if (given < count) begin
                r.underrun = 1'b1;
                // Only a short pull after output has begun counts against
                // the target; the bump also clamps a target above the maximum.
                if (rendering) begin
                    next_ms = 32'(level_ms) + 32'(cfg_bump);
                    if (next_ms > cfg_tmax) next_ms = cfg_tmax;
                    level_ms   = next_ms[MS_W-1:0];
                    ticks_idle = '0;
                end
            end
        end else if (func == FUNC_TICK) begin
            if (ticks_idle != TICK_MAX) ticks_idle = ticks_idle + 24'd1;
        end
        r.bytes_given  = given[15:0];
        r.target_now   = level_ms;
        r.queued_bytes = queued_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result %0d, %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        fault_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes its outputs at the falling edge. A word stays
    // offered until it has been taken; between words it idles at random.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        bus_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (outgoing_words.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                w = outgoing_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.count;
                s_axis_tuser  <= w.func;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus a long hold-off whenever one is
    // requested, so that the block fills up and refuses input for a while.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_served  <= holds_served + 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge the result side is checked first, then
    // an accepted input word is run through the predictor. A result can
    // never belong to a word taken at the same edge, so the order is safe.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
                if (awaited_status.size() == 0) begin
                    report_mismatch("result word with none awaited", m_axis_tdata, 0);
                end else begin
                    want = awaited_status.pop_front();
                    if (got.bytes_given != want.bytes_given)
                        report_mismatch("bytes_given", got.bytes_given, want.bytes_given);
                    if (got.underrun != want.underrun)
                        report_mismatch("underrun", got.underrun, want.underrun);
                    if (got.dropped_packets != want.dropped_packets)
                        report_mismatch("dropped_packets", got.dropped_packets,
                                        want.dropped_packets);
                    if (got.target_now != want.target_now)
                        report_mismatch("target_now", got.target_now, want.target_now);
                    if (got.queued_bytes != want.queued_bytes)
                        report_mismatch("queued_bytes", got.queued_bytes, want.queued_bytes);
                    if (got.overflow != want.overflow)
                        report_mismatch("overflow", got.overflow, want.overflow);
                    if (m_axis_tdata[63:$bits(res_t)] != '0)
                        report_mismatch("padding bits", m_axis_tdata[63:$bits(res_t)], 0);
                    results_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_status.push_back(account_op(s_axis_tuser, s_axis_tdata));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [1:0] func, input logic [15:0] count);
        bus_word_t w;
        w.func  = func;
        w.count = count;
        outgoing_words.push_back(w);
        words_queued++;
    endtask

    // Waits until every word sent has had its result, then lets the block
    // settle before anything else happens.
    task automatic wait_until_drained();
        while (results_seen != words_queued) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes one register and updates the predictor's copy of it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BYTES_PER_MS:   cfg_bpm      = value[BPM_W-1:0];
            CFG_TARGET_MIN_MS:  cfg_tmin     = value[MS_W-1:0];
            CFG_TARGET_MAX_MS:  cfg_tmax     = value[MS_W-1:0];
            CFG_BUMP_MS:        cfg_bump     = value[MS_W-1:0];
            CFG_DECAY_MS:       cfg_decay    = value[MS_W-1:0];
            CFG_DECAY_INTERVAL: cfg_interval = value[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Byte counts mostly look like real packets of a few milliseconds at
    // the current rate, with zero, full scale and arbitrary counts mixed in.
    function automatic logic [15:0] draw_byte_count();
        int          roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 4) return 16'd0;
        if (roll < 8) return 16'hFFFF;
        if (roll < 20) return 16'($urandom_range(65535));
        n = ((cfg_bpm == '0) ? 192 : 32'(cfg_bpm)) * $urandom_range(1, 25);
        return (n > 65535) ? 16'hFFFF : 16'(n);
    endfunction

    task automatic queue_random_word(input int push_pct, input int pull_pct);
        int         roll;
        logic [1:0] func;
        roll = $urandom_range(99);
        if (roll < push_pct)                 func = FUNC_PUSH;
        else if (roll < push_pct + pull_pct) func = FUNC_PULL;
        else if (roll < 96)                  func = FUNC_TICK;
        else                                 func = FUNC_UNKNOWN;
        queue_word(func, draw_byte_count());
    endtask

    // One phase: wait for the block to go idle, write every register, then
    // queue a batch of random words. Optionally the receiver holds off while
    // the batch is offered, or the sender stops half way until all results
    // are in.
    task automatic run_phase(input int bpm, input int tmin, input int tmax,
                             input int bump, input int decay, input int interval,
                             input int push_pct, input int pull_pct,
                             input bit hold_rx, input bit pause_mid);
        wait_until_drained();
        write_register(CFG_BYTES_PER_MS,   CFG_DATA_W'(bpm));
        write_register(CFG_TARGET_MIN_MS,  CFG_DATA_W'(tmin));
        write_register(CFG_TARGET_MAX_MS,  CFG_DATA_W'(tmax));
        write_register(CFG_BUMP_MS,        CFG_DATA_W'(bump));
        write_register(CFG_DECAY_MS,       CFG_DATA_W'(decay));
        write_register(CFG_DECAY_INTERVAL, CFG_DATA_W'(interval));
        for (int i = 0; i < PHASE_WORDS; i++) begin
            if (pause_mid && i == PHASE_WORDS / 2) wait_until_drained();
            queue_random_word(push_pct, pull_pct);
        end
        if (hold_rx) holds_asked++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening under the reset settings.
        queue_word(FUNC_PULL, 16'd100);      // short pull before any packet: flag only
        queue_word(FUNC_PULL, 16'd0);        // zero-byte pull is no underrun
        queue_word(FUNC_PUSH, 16'd0);        // empty push changes nothing
        queue_word(FUNC_TICK, 16'hFFFF);     // count is ignored on a tick
        queue_word(FUNC_UNKNOWN, 16'hFFFF);  // unknown function reports state only
        queue_word(FUNC_PUSH, 16'd1000);
        queue_word(FUNC_PUSH, 16'hFFFF);     // crosses the watermark, both packets go
        queue_word(FUNC_PUSH, 16'd3000);
        queue_word(FUNC_PUSH, 16'd4000);
        queue_word(FUNC_PULL, 16'd1000);     // partial packet
        queue_word(FUNC_PULL, 16'd2500);     // finishes one packet, starts the next
        queue_word(FUNC_PULL, 16'd10000);    // short pull after output began: bump
        queue_word(FUNC_PULL, 16'd0);
        queue_word(FUNC_PUSH, 16'h5555);
        queue_word(FUNC_PULL, 16'hAAAA);
        queue_word(FUNC_TICK, 16'd0);

        // Zero rate: no decay and no watermark, so the ring fills and the
        // full-store overflow is reached.
        run_phase(0, 40, 400, 30, 5, 10000, 75, 15, 1'b0, 1'b0);
        // Lowest settings: after a bump clamps the target to zero, pushes drop everything.
        run_phase(1, 0, 0, 0, 0, 1, 45, 35, 1'b0, 1'b0);
        // Highest settings, but for 2048 bytes per millisecond.
        run_phase(2048, 1023, 1023, 1023, 1023, 24'hFFFFFF, 45, 35, 1'b0, 1'b0);
        // Minimum above maximum: a bump pulls a high target down. The receiver
        // also holds off here while the sender keeps offering words.
        run_phase(96, 300, 100, 50, 20, 3, 45, 35, 1'b1, 1'b0);
        // A calm stretch with no idling on either side; a decay interval of one tick.
        calm = 1'b1;
        run_phase(48, 10, 1023, 1023, 1023, 1, 45, 30, 1'b0, 1'b0);
        wait_until_drained();
        calm = 1'b0;
        // Random settings; the first of these pauses the sender half way.
        for (int k = 0; k < 4; k++) begin
            run_phase($urandom_range(1, 2048), $urandom_range(0, 120),
                      $urandom_range(0, 1023), $urandom_range(0, 200),
                      $urandom_range(0, 60), $urandom_range(1, 40),
                      45, 35, 1'b0, k == 0);
        end

        wait_until_drained();
        if (fault_count == 0 && awaited_status.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20ms;
        $display("%0t: run limit reached, %0d results outstanding",
                 $time, words_queued - results_seen);
        $display("Test completed with failures");
        $finish;
    end

endmodule
